>>> rtl/core/cvg_pkg.sv
// Cylinder vertex generator: shared constants, types and small functions.
// No dependencies; every other file of the block imports this package.
package cvg_pkg;

  localparam int MAX_SEGMENTS  = 1024;
  localparam int CORDIC_STEPS  = 16;

  localparam int SEG_W      = 10;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int NUM_ROWS   = 4;
  localparam int COEF_W     = 16;

  localparam int PH_W       = 32;
  localparam int PH_STAGES  = 4;
  localparam int PH_BITS    = PH_W / PH_STAGES;
  localparam int REM_W      = CNT_W + 1;

  localparam int CO_W       = 34;
  localparam int ANG_W      = 33;
  localparam int ANG_FRAC   = 30;
  localparam int PROD_W     = (PH_W - 2) + 31;

  localparam int SUM_W      = 50;
  localparam int RES_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = RES_W - 1;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int FRONT_LAT  = PH_STAGES + CORDIC_LAT;
  localparam int DIV_LAT    = QUO_W + 3;
  localparam int XFORM_LAT  = 3;
  localparam int BACK_LAT   = XFORM_LAT + DIV_LAT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int VIDX_W      = 3;
  localparam int SHELL_VERTS = 6;
  localparam int CAP_VERTS   = 3;

  localparam int SEG_COUNT_RESET = 16;
  localparam int UNITY_Q12       = 4096;

  localparam logic [30:0]            HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [CO_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3      = 3'd5;

  typedef enum logic [1:0] {
    CMD_SHELL  = 2'd0,
    CMD_TOP    = 2'd1,
    CMD_BOTTOM = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CNT_W-1:0]                  seg_count;
    logic                              caps_en;
    logic [NUM_ROWS-1:0][CFG_W-1:0]    rows;
  } cfg_t;

  typedef struct packed {
    cmd_e                   cmd;
    logic signed [CO_W-1:0] pc;
    logic signed [CO_W-1:0] ps;
    logic signed [CO_W-1:0] cc;
    logic signed [CO_W-1:0] cs;
  } seg_item_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int k);
    case (k)
      0:  return 33'sd843314857;
      1:  return 33'sd497837829;
      2:  return 33'sd263043837;
      3:  return 33'sd133525159;
      4:  return 33'sd67021687;
      5:  return 33'sd33543516;
      6:  return 33'sd16775851;
      7:  return 33'sd8388437;
      8:  return 33'sd4194283;
      9:  return 33'sd2097149;
      10: return 33'sd1048576;
      11: return 33'sd524288;
      12: return 33'sd262144;
      13: return 33'sd131072;
      14: return 33'sd65536;
      15: return 33'sd32768;
      16: return 33'sd16384;
      17: return 33'sd8192;
      18: return 33'sd4096;
      19: return 33'sd2048;
      20: return 33'sd1024;
      21: return 33'sd512;
      22: return 33'sd256;
      23: return 33'sd128;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] row,
                                                   input int col);
    return signed'(row[col*COEF_W +: COEF_W]);
  endfunction

endpackage

>>> rtl/core/cvg_cordic.sv
// Pipelined CORDIC lane: turn fraction in, cosine and sine out in Q4.30 (34-bit signed).
// Depends on cvg_pkg (step count, arctangent table, gain).
module cvg_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [cvg_pkg::PH_W-1:0]            phase_i,
  output logic signed [cvg_pkg::CO_W-1:0]     cos_o,
  output logic signed [cvg_pkg::CO_W-1:0]     sin_o
);
  import cvg_pkg::*;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  logic [PROD_W-1:0]       prod;
  logic signed [CO_W-1:0]  x_q [CORDIC_STEPS+1];
  logic signed [CO_W-1:0]  y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];
  logic [1:0]              quad_q [CORDIC_STEPS+1];

  assign prod = phase_i[PH_W-3:0] * HALF_PI_Q30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= signed'({2'b00, prod[PROD_W-1:ANG_FRAC]});
      quad_q[0] <= phase_i[PH_W-1:PH_W-2];
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][ANG_W-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - atan_q30(k);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + atan_q30(k);
        end
        quad_q[k+1] <= quad_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[CORDIC_STEPS])
        QUAD_I: begin
          cos_o <= x_q[CORDIC_STEPS];
          sin_o <= y_q[CORDIC_STEPS];
        end
        QUAD_II: begin
          cos_o <= -y_q[CORDIC_STEPS];
          sin_o <= x_q[CORDIC_STEPS];
        end
        QUAD_III: begin
          cos_o <= -x_q[CORDIC_STEPS];
          sin_o <= -y_q[CORDIC_STEPS];
        end
        QUAD_IV: begin
          cos_o <= y_q[CORDIC_STEPS];
          sin_o <= -x_q[CORDIC_STEPS];
        end
        default: begin
          cos_o <= x_q[CORDIC_STEPS];
          sin_o <= y_q[CORDIC_STEPS];
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cvg_front.sv
// Front end: takes transactions, drops empty ones, finds both segment angles
// and their cosine/sine. Depends on cvg_pkg and cvg_cordic.
module cvg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cvg_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [cvg_pkg::SEG_W-1:0]   segment_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output cvg_pkg::seg_item_t          q_item_o
);
  import cvg_pkg::*;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] seg_ext;
  logic [CNT_W-1:0] seg_nxt;
  logic             keep;
  logic             en;
  logic             accept;

  logic [FRONT_LAT:0] v_q;
  cmd_e               cmd_q [FRONT_LAT+1];

  logic [REM_W-1:0] rem_d [2][PH_STAGES+1];
  logic [REM_W-1:0] rem_q [2][PH_STAGES+1];
  logic [PH_W-1:0]  quo_d [2][PH_STAGES+1];
  logic [PH_W-1:0]  quo_q [2][PH_STAGES+1];

  logic signed [CO_W-1:0] pc, ps, cc, cs;

  always_comb begin
    if (cfg_i.seg_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_i.seg_count > CNT_W'(MAX_SEGMENTS)) begin
      n_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_eff = cfg_i.seg_count;
    end
    seg_ext = CNT_W'(segment_i);
    seg_nxt = seg_ext + CNT_W'(1);
    keep = (seg_ext < n_eff) &&
           ((cmd_i == CMD_SHELL) ||
            (cfg_i.caps_en && ((cmd_i == CMD_TOP) || (cmd_i == CMD_BOTTOM))));
  end

  assign en         = !(v_q[FRONT_LAT] && q_full_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign q_push_o   = v_q[FRONT_LAT] && en;

  // long division k * 2^32 / n, eight quotient bits per stage
  always_comb begin
    logic [REM_W-1:0] r;
    logic [PH_W-1:0]  qb;
    rem_d[0][0] = REM_W'(seg_ext);
    rem_d[1][0] = (seg_nxt == n_eff) ? '0 : REM_W'(seg_nxt);
    quo_d[0][0] = '0;
    quo_d[1][0] = '0;
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < PH_STAGES; s++) begin
        r  = rem_q[l][s];
        qb = quo_q[l][s];
        for (int b = 0; b < PH_BITS; b++) begin
          r = {r[REM_W-2:0], 1'b0};
          if (r >= REM_W'(n_eff)) begin
            r  = r - REM_W'(n_eff);
            qb = {qb[PH_W-2:0], 1'b1};
          end else begin
            qb = {qb[PH_W-2:0], 1'b0};
          end
        end
        rem_d[l][s+1] = r;
        quo_d[l][s+1] = qb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        for (int s = 0; s <= PH_STAGES; s++) begin
          rem_q[l][s] <= rem_d[l][s];
          quo_q[l][s] <= quo_d[l][s];
        end
      end
      cmd_q[0] <= cmd_e'(cmd_i);
      for (int s = 1; s <= FRONT_LAT; s++) begin
        cmd_q[s] <= cmd_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FRONT_LAT-1:0], accept && keep};
    end
  end

  cvg_cordic u_cordic_p (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (quo_q[0][PH_STAGES]),
    .cos_o   (pc),
    .sin_o   (ps)
  );

  cvg_cordic u_cordic_c (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (quo_q[1][PH_STAGES]),
    .cos_o   (cc),
    .sin_o   (cs)
  );

  always_comb begin
    q_item_o.cmd = cmd_q[FRONT_LAT];
    q_item_o.pc  = pc;
    q_item_o.ps  = ps;
    q_item_o.cc  = cc;
    q_item_o.cs  = cs;
  end

endmodule

>>> rtl/core/cvg_queue.sv
// Four-entry queue of segment work between front and back ends.
// Depends on cvg_pkg (seg_item_t, depth).
module cvg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cvg_pkg::seg_item_t  item_i,
  input  logic                pop_i,
  output cvg_pkg::seg_item_t  item_o,
  output logic                full_o,
  output logic                empty_o
);
  import cvg_pkg::*;

  seg_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

>>> rtl/core/cvg_div.sv
// Pipelined signed divider lane: Q16.16 quotient num/den, saturated,
// one quotient bit per stage. Depends on cvg_pkg.
module cvg_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [cvg_pkg::SUM_W-1:0]  num_i,
  input  logic signed [cvg_pkg::SUM_W-1:0]  den_i,
  output logic signed [cvg_pkg::RES_W-1:0]  quo_o
);
  import cvg_pkg::*;

  localparam int OVF_SH = QUO_W - FRAC_W;

  logic [SUM_W-1:0] un_q, ud_q;
  logic             neg_q, nz_q;

  logic [SUM_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] qb_q  [QUO_W+1];
  logic [SUM_W-1:0] udp_q [QUO_W+1];
  logic             negp_q [QUO_W+1];
  logic             nzp_q  [QUO_W+1];
  logic             ovf_q  [QUO_W+1];

  logic [RES_W-1:0] qext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      un_q  <= num_i[SUM_W-1] ? (~num_i + SUM_W'(1)) : num_i;
      ud_q  <= den_i[SUM_W-1] ? (~den_i + SUM_W'(1)) : den_i;
      neg_q <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
      nz_q  <= (num_i != '0);

      rem_q[0]  <= un_q >> OVF_SH;
      qb_q[0]   <= {un_q[OVF_SH-1:0], {FRAC_W{1'b0}}};
      udp_q[0]  <= ud_q;
      negp_q[0] <= neg_q;
      nzp_q[0]  <= nz_q;
      ovf_q[0]  <= ({{OVF_SH{1'b0}}, un_q} >= {ud_q, {OVF_SH{1'b0}}});
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_bit
    logic [SUM_W:0] t;
    assign t = {rem_q[s], qb_q[s][QUO_W-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t >= {1'b0, udp_q[s]}) begin
          rem_q[s+1] <= SUM_W'(t - {1'b0, udp_q[s]});
          qb_q[s+1]  <= {qb_q[s][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= SUM_W'(t);
          qb_q[s+1]  <= {qb_q[s][QUO_W-2:0], 1'b0};
        end
        udp_q[s+1]  <= udp_q[s];
        negp_q[s+1] <= negp_q[s];
        nzp_q[s+1]  <= nzp_q[s];
        ovf_q[s+1]  <= ovf_q[s];
      end
    end
  end

  assign qext = {1'b0, qb_q[QUO_W]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!nzp_q[QUO_W]) begin
        quo_o <= '0;
      end else if (ovf_q[QUO_W]) begin
        quo_o <= negp_q[QUO_W] ? RES_MIN : RES_MAX;
      end else begin
        quo_o <= negp_q[QUO_W] ? (~qext + RES_W'(1)) : qext;
      end
    end
  end

endmodule

>>> rtl/core/cvg_back.sv
// Back end: walks the vertices of each queued segment, applies the matrix
// and divides by w. Depends on cvg_pkg and cvg_div.
module cvg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cvg_pkg::cfg_t                     cfg_i,
  input  logic                              q_empty_i,
  input  cvg_pkg::seg_item_t                q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_x_o,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_y_o,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_z_o,
  output logic                              last_vertex_o
);
  import cvg_pkg::*;

  logic              en, issue, last_v;
  logic [VIDX_W-1:0] vidx_q, vidx_d, nverts;
  logic              xone, origin, use_c;
  logic signed [CO_W-1:0] vy, vz;

  logic [BACK_LAT-1:0] vp_q, lp_q;

  logic                   t1_xone_q;
  logic signed [CO_W-1:0] t1_y_q, t1_z_q;

  logic signed [SUM_W-1:0] p1 [NUM_ROWS];
  logic signed [SUM_W-1:0] p2 [NUM_ROWS];
  logic signed [SUM_W-1:0] base [NUM_ROWS];
  logic signed [SUM_W-1:0] p1_q [NUM_ROWS];
  logic signed [SUM_W-1:0] p2_q [NUM_ROWS];
  logic signed [SUM_W-1:0] base_q [NUM_ROWS];
  logic signed [SUM_W-1:0] sum_q [NUM_ROWS];

  assign en    = !(out_valid_o && out_stall_i);
  assign issue = en && !q_empty_i;

  always_comb begin
    nverts  = (q_item_i.cmd == CMD_SHELL) ? VIDX_W'(SHELL_VERTS) : VIDX_W'(CAP_VERTS);
    last_v  = (vidx_q == nverts - VIDX_W'(1));
    q_pop_o = issue && last_v;
    vidx_d  = vidx_q;
    if (issue) begin
      vidx_d = last_v ? '0 : vidx_q + VIDX_W'(1);
    end
  end

  always_comb begin
    xone   = 1'b0;
    origin = 1'b0;
    use_c  = 1'b0;
    case (q_item_i.cmd)
      CMD_SHELL: begin
        xone  = (vidx_q == 3'd2) || (vidx_q == 3'd4) || (vidx_q == 3'd5);
        use_c = (vidx_q == 3'd1) || (vidx_q == 3'd3) || (vidx_q == 3'd4);
      end
      CMD_TOP: begin
        xone   = 1'b1;
        origin = (vidx_q == 3'd0);
        use_c  = (vidx_q == 3'd2);
      end
      CMD_BOTTOM: begin
        origin = (vidx_q == 3'd0);
        use_c  = (vidx_q == 3'd1);
      end
      default: ;
    endcase
    if (origin) begin
      vy = '0;
      vz = '0;
    end else if (use_c) begin
      vy = q_item_i.cc;
      vz = q_item_i.cs;
    end else begin
      vy = q_item_i.pc;
      vz = q_item_i.ps;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      p1[r]   = coef(cfg_i.rows[r], 1) * t1_y_q;
      p2[r]   = coef(cfg_i.rows[r], 2) * t1_z_q;
      base[r] = (SUM_W'(coef(cfg_i.rows[r], 3)) <<< ANG_FRAC) +
                (t1_xone_q ? (SUM_W'(coef(cfg_i.rows[r], 0)) <<< ANG_FRAC) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_xone_q <= xone;
      t1_y_q    <= vy;
      t1_z_q    <= vz;
      for (int r = 0; r < NUM_ROWS; r++) begin
        p1_q[r]   <= p1[r];
        p2_q[r]   <= p2[r];
        base_q[r] <= base[r];
        sum_q[r]  <= base_q[r] + p1_q[r] + p2_q[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vidx_q <= '0;
      vp_q   <= '0;
      lp_q   <= '0;
    end else begin
      vidx_q <= vidx_d;
      if (en) begin
        vp_q <= {vp_q[BACK_LAT-2:0], issue};
        lp_q <= {lp_q[BACK_LAT-2:0], last_v};
      end
    end
  end

  cvg_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sum_q[0]),
    .den_i (sum_q[3]),
    .quo_o (vert_x_o)
  );

  cvg_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sum_q[1]),
    .den_i (sum_q[3]),
    .quo_o (vert_y_o)
  );

  cvg_div u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sum_q[2]),
    .den_i (sum_q[3]),
    .quo_o (vert_z_o)
  );

  assign out_valid_o   = vp_q[BACK_LAT-1];
  assign last_vertex_o = lp_q[BACK_LAT-1];

endmodule

>>> rtl/core/cylinder_vertex_generator_top.sv
// Cylinder vertex generator top: config registers, front end, queue, back end.
// Throughput: one vertex per cycle from the back-end sequencer while it has
// queued work and the output is not stalled: six vertices per shell transaction,
// three per cap; transactions with no vertices are dropped in the front end.
// Reset: config returns to N=16, caps off, identity matrix; pipelines empty.
// Depends on cvg_pkg, cvg_front, cvg_queue, cvg_back.
module cylinder_vertex_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic [cvg_pkg::SEG_W-1:0]         segment_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_x_o,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_y_o,
  output logic signed [cvg_pkg::RES_W-1:0]  vert_z_o,
  output logic                              last_vertex_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cvg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cvg_pkg::CFG_W-1:0]         cfg_data_i
);
  import cvg_pkg::*;

  logic [CNT_W-1:0]               seg_count_q;
  logic                           caps_q;
  logic [NUM_ROWS-1:0][CFG_W-1:0] rows_q;
  cfg_t                           cfg;

  logic      q_push, q_pop, q_full, q_empty;
  seg_item_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= CNT_W'(SEG_COUNT_RESET);
      caps_q      <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_q[r] <= CFG_W'(UNITY_Q12) << (COEF_W * r);
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEG_COUNT: seg_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_CAPS:      caps_q      <= cfg_data_i[0];
        CFG_ROW0:      rows_q[0]   <= cfg_data_i;
        CFG_ROW1:      rows_q[1]   <= cfg_data_i;
        CFG_ROW2:      rows_q[2]   <= cfg_data_i;
        CFG_ROW3:      rows_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seg_count = seg_count_q;
    cfg.caps_en   = caps_q;
    cfg.rows      = rows_q;
  end

  cvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .segment_i  (segment_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  cvg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cvg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vert_x_o      (vert_x_o),
    .vert_y_o      (vert_y_o),
    .vert_z_o      (vert_z_o),
    .last_vertex_o (last_vertex_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full) else $error("front stalled with queue space");

endmodule
